/* src/tmqs_pkg.sv */
`default_nettype none

package tmqs_pkg;

  // field widths
  localparam int unsigned TYPE_W   = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned QCOUNT_W = 5;

  // operation codes carried by kind
  typedef enum logic {
    KIND_SEND = 1'b0,
    KIND_RECV = 1'b1
  } kind_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_BADLEN = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOMSG  = 3'd3,
    ST_TOOBIG = 3'd4
  } status_e;

  // selector match rule broadcast to every cell
  typedef enum logic [1:0] {
    SEL_ANY   = 2'd0,
    SEL_EXACT = 2'd1,
    SEL_BELOW = 2'd2
  } sel_mode_e;

  typedef struct packed {
    sel_mode_e          mode;
    logic signed [31:0] value;
    logic signed [32:0] bound;
  } sel_t;

endpackage

`default_nettype wire

/* src/typed_message_queue_select_core.sv */
`default_nettype none

// Typed message queue with selective receive, held in a row of entry cells.
// Command channel: present kind_i, mtype_i, msg_length_i, payload_i and
// no_error_i with start high; the command transfers at the rising edge where
// start is high and busy is low. A send appends an entry; a receive removes
// the first entry in arrival order whose type matches the selector.
// Every cell compares its type with the selector in the transfer cycle and
// stores a match flag. The next cycle (busy high) picks the first flag,
// builds the result and moves the cells behind the taken entry down by one.
// The result is registered at the end of that cycle and shows on the result
// ports for exactly one cycle with done_o high; busy is low again in that
// cycle, so a new command can transfer while the result is shown. Each
// command passes the compare cycle and then the select-and-compact cycle
// over the cells before the next command is taken.
// The receiver cannot hold results off; every result transfers on done_o.
// Reset empties the queue (count to zero) and clears busy and done_o;
// cell contents are not cleared and are never read before being written.
module typed_message_queue_select_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  kind_i,
  input  wire  signed [tmqs_pkg::TYPE_W-1:0]   mtype_i,
  input  wire         [tmqs_pkg::LEN_W-1:0]    msg_length_i,
  input  wire         [tmqs_pkg::PAY_W-1:0]    payload_i,
  input  wire                                  no_error_i,
  output logic                                 done_o,
  output logic        [tmqs_pkg::STATUS_W-1:0] status_o,
  output logic signed [tmqs_pkg::TYPE_W-1:0]   out_type_o,
  output logic        [tmqs_pkg::LEN_W-1:0]    out_length_o,
  output logic        [tmqs_pkg::PAY_W-1:0]    out_payload_o,
  output logic        [tmqs_pkg::QCOUNT_W-1:0] queued_count_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'b01,
    PH_COMMIT = 2'b10
  } phase_e;

  phase_e phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;

  // captured command
  logic                               kind_q;
  logic signed [tmqs_pkg::TYPE_W-1:0] type_q;
  logic        [tmqs_pkg::LEN_W-1:0]  len_q;
  logic        [tmqs_pkg::PAY_W-1:0]  pay_q;
  logic                               noerr_q;

  logic                               cmd_xfer;
  logic                               commit;
  tmqs_pkg::sel_t                     sel;

  logic signed [tmqs_pkg::TYPE_W-1:0] cell_type    [QUEUE_DEPTH];
  logic        [tmqs_pkg::LEN_W-1:0]  cell_length  [QUEUE_DEPTH];
  logic        [tmqs_pkg::PAY_W-1:0]  cell_payload [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]             match;
  logic [QUEUE_DEPTH-1:0]             match_m1;
  logic [QUEUE_DEPTH-1:0]             first_hit;
  logic [QUEUE_DEPTH-1:0]             shift_mask;

  logic signed [tmqs_pkg::TYPE_W-1:0] pick_type;
  logic        [tmqs_pkg::LEN_W-1:0]  pick_length;
  logic        [tmqs_pkg::PAY_W-1:0]  pick_payload;

  logic                               send_ok;
  logic                               recv_ok;
  tmqs_pkg::status_e                  status_d;
  logic signed [tmqs_pkg::TYPE_W-1:0] res_type_d;
  logic        [tmqs_pkg::LEN_W-1:0]  res_len_d;
  logic        [tmqs_pkg::PAY_W-1:0]  res_pay_d;
  logic [31:0]                        count_ext;

  logic                               done_q;
  logic        [tmqs_pkg::STATUS_W-1:0] status_q;
  logic signed [tmqs_pkg::TYPE_W-1:0] res_type_q;
  logic        [tmqs_pkg::LEN_W-1:0]  res_len_q;
  logic        [tmqs_pkg::PAY_W-1:0]  res_pay_q;
  logic        [tmqs_pkg::QCOUNT_W-1:0] qcount_q;

  assign busy     = (phase_q == PH_COMMIT);
  assign cmd_xfer = start && !busy;
  assign commit   = (phase_q == PH_COMMIT);

  // selector broadcast from the command ports
  always_comb begin
    sel.value = mtype_i;
    sel.bound = 33'sd0 - $signed({mtype_i[31], mtype_i});
    if (mtype_i == 32'sd0) begin
      sel.mode = tmqs_pkg::SEL_ANY;
    end else if (mtype_i[31]) begin
      sel.mode = tmqs_pkg::SEL_BELOW;
    end else begin
      sel.mode = tmqs_pkg::SEL_EXACT;
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_xfer) begin
      kind_q  <= kind_i;
      type_q  <= mtype_i;
      len_q   <= msg_length_i;
      pay_q   <= payload_i;
      noerr_q <= no_error_i;
    end
  end

  // row of entry cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [tmqs_pkg::TYPE_W-1:0] nxt_type;
    logic        [tmqs_pkg::LEN_W-1:0]  nxt_length;
    logic        [tmqs_pkg::PAY_W-1:0]  nxt_payload;
    logic                               shift_en;

    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nxt_type    = cell_type[i+1];
      assign nxt_length  = cell_length[i+1];
      assign nxt_payload = cell_payload[i+1];
      assign shift_en    = commit && recv_ok && shift_mask[i];
    end else begin : g_last
      assign nxt_type    = '0;
      assign nxt_length  = '0;
      assign nxt_payload = '0;
      assign shift_en    = 1'b0;
    end

    tmqs_cell u_cell (
      .clk_i          (clk_i),
      .sel_i          (sel),
      .valid_i        (CW'(i) < count_q),
      .capture_i      (cmd_xfer),
      .load_i         (commit && send_ok && (count_q == CW'(i))),
      .shift_i        (shift_en),
      .new_type_i     (type_q),
      .new_length_i   (len_q),
      .new_payload_i  (pay_q),
      .next_type_i    (nxt_type),
      .next_length_i  (nxt_length),
      .next_payload_i (nxt_payload),
      .type_o         (cell_type[i]),
      .length_o       (cell_length[i]),
      .payload_o      (cell_payload[i]),
      .match_o        (match[i])
    );
  end

  // first match and the cells at or behind it
  assign match_m1   = match - QUEUE_DEPTH'(1);
  assign first_hit  = match & ~match_m1;
  assign shift_mask = ~(match_m1 & ~match);

  // one-hot pick of the taken entry
  always_comb begin
    pick_type    = '0;
    pick_length  = '0;
    pick_payload = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first_hit[i]) begin
        pick_type    = pick_type | cell_type[i];
        pick_length  = pick_length | cell_length[i];
        pick_payload = pick_payload | cell_payload[i];
      end
    end
  end

  // result and count update
  always_comb begin
    send_ok    = 1'b0;
    recv_ok    = 1'b0;
    status_d   = tmqs_pkg::ST_OK;
    res_type_d = '0;
    res_len_d  = '0;
    res_pay_d  = '0;
    count_d    = count_q;
    if (kind_q == tmqs_pkg::KIND_SEND) begin
      if (len_q == '0) begin
        status_d = tmqs_pkg::ST_BADLEN;
      end else if (count_q == CW'(QUEUE_DEPTH)) begin
        status_d = tmqs_pkg::ST_FULL;
      end else begin
        send_ok = 1'b1;
        count_d = count_q + CW'(1);
      end
    end else begin
      if (len_q == '0) begin
        status_d = tmqs_pkg::ST_BADLEN;
      end else if (match == '0) begin
        status_d = tmqs_pkg::ST_NOMSG;
      end else if ((pick_length > len_q) && !noerr_q) begin
        status_d = tmqs_pkg::ST_TOOBIG;
      end else begin
        recv_ok    = 1'b1;
        res_type_d = pick_type;
        res_len_d  = (pick_length > len_q) ? len_q : pick_length;
        res_pay_d  = pick_payload;
        count_d    = count_q - CW'(1);
      end
    end
  end

  assign count_ext = 32'(count_d);

  // phase sequencing
  always_comb begin
    case (phase_q)
      PH_IDLE:   phase_d = cmd_xfer ? PH_COMMIT : PH_IDLE;
      PH_COMMIT: phase_d = PH_IDLE;
      default:   phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= commit;
      if (commit) begin
        count_q <= count_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q   <= status_d;
      res_type_q <= res_type_d;
      res_len_q  <= res_len_d;
      res_pay_q  <= res_pay_d;
      qcount_q   <= count_ext[tmqs_pkg::QCOUNT_W-1:0];
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_type_o     = res_type_q;
  assign out_length_o   = res_len_q;
  assign out_payload_o  = res_pay_q;
  assign queued_count_o = qcount_q;

`ifndef SYNTHESIS
  a_commit_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> done_q)
    else $error("result strobe missing after commit");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_single_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> $onehot0(first_hit))
    else $error("more than one entry picked");

  a_recv_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && recv_ok) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("receive did not remove one entry");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != tmqs_pkg::ST_OK) |->
      (res_type_q == '0 && res_len_q == '0 && res_pay_q == '0))
    else $error("error result carries message fields");
`endif

endmodule

`default_nettype wire

/* src/tmqs_cell.sv */
`default_nettype none

module tmqs_cell (
  input  wire                                  clk_i,
  input  wire  tmqs_pkg::sel_t                 sel_i,
  input  wire                                  valid_i,
  input  wire                                  capture_i,
  input  wire                                  load_i,
  input  wire                                  shift_i,
  input  wire  signed [tmqs_pkg::TYPE_W-1:0]   new_type_i,
  input  wire         [tmqs_pkg::LEN_W-1:0]    new_length_i,
  input  wire         [tmqs_pkg::PAY_W-1:0]    new_payload_i,
  input  wire  signed [tmqs_pkg::TYPE_W-1:0]   next_type_i,
  input  wire         [tmqs_pkg::LEN_W-1:0]    next_length_i,
  input  wire         [tmqs_pkg::PAY_W-1:0]    next_payload_i,
  output logic signed [tmqs_pkg::TYPE_W-1:0]   type_o,
  output logic        [tmqs_pkg::LEN_W-1:0]    length_o,
  output logic        [tmqs_pkg::PAY_W-1:0]    payload_o,
  output logic                                 match_o
);

  logic signed [tmqs_pkg::TYPE_W-1:0] type_q;
  logic        [tmqs_pkg::LEN_W-1:0]  length_q;
  logic        [tmqs_pkg::PAY_W-1:0]  payload_q;
  logic                               match_q;
  logic                               hit;

  // selector compare against the held type
  always_comb begin
    case (sel_i.mode)
      tmqs_pkg::SEL_ANY:   hit = 1'b1;
      tmqs_pkg::SEL_EXACT: hit = (type_q == sel_i.value);
      tmqs_pkg::SEL_BELOW: hit = ($signed({type_q[31], type_q}) < sel_i.bound);
      default:             hit = 1'b0;
    endcase
  end

  // match flag taken at command transfer
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      match_q <= valid_i & hit;
    end
  end

  // entry storage: append from the command or close up from the neighbor
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      type_q    <= new_type_i;
      length_q  <= new_length_i;
      payload_q <= new_payload_i;
    end else if (shift_i) begin
      type_q    <= next_type_i;
      length_q  <= next_length_i;
      payload_q <= next_payload_i;
    end
  end

  assign type_o    = type_q;
  assign length_o  = length_q;
  assign payload_o = payload_q;
  assign match_o   = match_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam int unsigned TYPE_W   = tmqs_pkg::TYPE_W;
  localparam int unsigned LEN_W    = tmqs_pkg::LEN_W;
  localparam int unsigned PAY_W    = tmqs_pkg::PAY_W;
  localparam int unsigned STATUS_W = tmqs_pkg::STATUS_W;
  localparam int unsigned QCOUNT_W = tmqs_pkg::QCOUNT_W;

  // one command as presented on the input ports
  typedef struct packed {
    tmqs_pkg::kind_e           kind;
    logic signed [TYPE_W-1:0]  mtype;
    logic        [LEN_W-1:0]   msg_length;
    logic        [PAY_W-1:0]   payload;
    logic                      no_error;
  } msg_cmd_t;

  // one result as seen on the result ports
  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [TYPE_W-1:0]   mtype;
    logic        [LEN_W-1:0]    msg_length;
    logic        [PAY_W-1:0]    payload;
    logic        [QCOUNT_W-1:0] queued_count;
  } msg_result_t;

  // mirror of the message queue plus the results it predicts
  class msg_queue_scoreboard;
    logic [TYPE_W-1:0] held_type [QUEUE_DEPTH];
    logic [LEN_W-1:0]  held_len  [QUEUE_DEPTH];
    logic [PAY_W-1:0]  held_pay  [QUEUE_DEPTH];
    int unsigned       held_count;
    msg_result_t       expected_results [$];
    int unsigned       error_count;

    function new();
      held_count  = 0;
      error_count = 0;
    endfunction

    // compare at 33 bits so a selector of -2^31 means below 2^31
    function bit selector_hit(logic signed [TYPE_W-1:0] sel,
                              logic signed [TYPE_W-1:0] typ);
      logic signed [TYPE_W:0] sel_w;
      logic signed [TYPE_W:0] typ_w;
      sel_w = sel;
      typ_w = typ;
      if (sel_w == 0) return 1'b1;
      if (sel_w > 0) return typ_w == sel_w;
      return typ_w < -sel_w;
    endfunction

    function msg_result_t predict_result(tmqs_pkg::kind_e kind,
                                         logic signed [TYPE_W-1:0] mtype,
                                         logic [LEN_W-1:0] len, logic [PAY_W-1:0] pay,
                                         logic no_error);
      msg_result_t res;
      int          hit;
      res        = '0;
      res.status = tmqs_pkg::ST_OK;
      hit        = -1;
      if (kind == tmqs_pkg::KIND_SEND) begin
        // zero length is reported ahead of a full queue
        if (len == 0) begin
          res.status = tmqs_pkg::ST_BADLEN;
        end else if (held_count >= QUEUE_DEPTH) begin
          res.status = tmqs_pkg::ST_FULL;
        end else begin
          held_type[held_count] = mtype;
          held_len[held_count]  = len;
          held_pay[held_count]  = pay;
          held_count++;
        end
      end else if (len == 0) begin
        res.status = tmqs_pkg::ST_BADLEN;
      end else begin
        // first match in arrival order
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && selector_hit(mtype, held_type[i])) hit = i;
        end
        if (hit < 0) begin
          res.status = tmqs_pkg::ST_NOMSG;
        end else if (held_len[hit] > len && !no_error) begin
          // oversize message stays queued in place
          res.status = tmqs_pkg::ST_TOOBIG;
        end else begin
          res.mtype      = held_type[hit];
          res.msg_length = (held_len[hit] > len) ? len : held_len[hit];
          res.payload    = held_pay[hit];
          // close up the gap behind the taken entry
          for (int i = hit; i + 1 < held_count; i++) begin
            held_type[i] = held_type[i + 1];
            held_len[i]  = held_len[i + 1];
            held_pay[i]  = held_pay[i + 1];
          end
          held_count--;
        end
      end
      res.queued_count = QCOUNT_W'(held_count);
      return res;
    endfunction

    function void note_command(tmqs_pkg::kind_e kind, logic signed [TYPE_W-1:0] mtype,
                               logic [LEN_W-1:0] len, logic [PAY_W-1:0] pay,
                               logic no_error);
      expected_results.push_back(predict_result(kind, mtype, len, pay, no_error));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic signed [TYPE_W-1:0] typ,
                               logic [LEN_W-1:0] len, logic [PAY_W-1:0] pay,
                               logic [QCOUNT_W-1:0] count);
      msg_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual status %0d",
                 $time, status);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, status);
      compare_field("out_type", want.mtype, typ);
      compare_field("out_length", want.msg_length, len);
      compare_field("out_payload", want.payload, pay);
      compare_field("queued_count", want.queued_count, count);
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic                       kind_i;
  logic signed [TYPE_W-1:0]   mtype_i;
  logic        [LEN_W-1:0]    msg_length_i;
  logic        [PAY_W-1:0]    payload_i;
  logic                       no_error_i;
  logic                       done_o;
  logic        [STATUS_W-1:0] status_o;
  logic signed [TYPE_W-1:0]   out_type_o;
  logic        [LEN_W-1:0]    out_length_o;
  logic        [PAY_W-1:0]    out_payload_o;
  logic        [QCOUNT_W-1:0] queued_count_o;

  msg_queue_scoreboard queue_sb = new();
  int unsigned         cycle_count = 0;

  typed_message_queue_select_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .mtype_i       (mtype_i),
    .msg_length_i  (msg_length_i),
    .payload_i     (payload_i),
    .no_error_i    (no_error_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_type_o    (out_type_o),
    .out_length_o  (out_length_o),
    .out_payload_o (out_payload_o),
    .queued_count_o(queued_count_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("typed_message_queue_select_core: mismatch");
      $finish;
    end
  end

  // result check first, then note a command transfer on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        queue_sb.check_result(status_o, out_type_o, out_length_o, out_payload_o,
                              queued_count_o);
      end
      if (start && !busy) begin
        queue_sb.note_command(tmqs_pkg::kind_e'(kind_i), mtype_i, msg_length_i,
                              payload_i, no_error_i);
      end
    end
  end

  function automatic msg_cmd_t make_cmd(tmqs_pkg::kind_e kind, logic [TYPE_W-1:0] mtype,
                                        logic [LEN_W-1:0] len, logic [PAY_W-1:0] pay,
                                        logic no_error);
    msg_cmd_t cmd;
    cmd.kind       = kind;
    cmd.mtype      = mtype;
    cmd.msg_length = len;
    cmd.payload    = pay;
    cmd.no_error   = no_error;
    return cmd;
  endfunction

  // small pool of types so that selectors hit often
  function automatic logic [TYPE_W-1:0] pick_type();
    case ($urandom_range(0, 9))
      6:       return 32'h7FFF_FFFF;
      7:       return 32'h8000_0000;
      8, 9:    return $urandom;
      default: return $urandom_range(0, 12) - 4;
    endcase
  endfunction

  function automatic logic [TYPE_W-1:0] pick_selector();
    case ($urandom_range(0, 8))
      0:       return '0;
      5, 6:    return -$urandom_range(1, 9);
      7:       return 32'h8000_0000;
      8:       return $urandom;
      default: return pick_type();
    endcase
  endfunction

  // mostly short lengths so oversize and truncation both show up
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (calm || roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic msg_cmd_t random_command(int unsigned send_pct);
    if ($urandom_range(1, 100) <= send_pct) begin
      return make_cmd(tmqs_pkg::KIND_SEND, pick_type(), pick_length(), $urandom,
                      1'($urandom_range(0, 1)));
    end
    return make_cmd(tmqs_pkg::KIND_RECV, pick_selector(), pick_length(), $urandom,
                    1'($urandom_range(0, 1)));
  endfunction

  // present one command at a falling edge and hold it until it transfers
  task automatic issue_command(msg_cmd_t cmd, int unsigned gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i       = cmd.kind;
    mtype_i      = cmd.mtype;
    msg_length_i = cmd.msg_length;
    payload_i    = cmd.payload;
    no_error_i   = cmd.no_error;
    start        = 1'b1;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off until every predicted result has come back
  task automatic wait_for_drain();
    start = 1'b0;
    while (queue_sb.expected_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned issued;
    int unsigned burst_len;
    int unsigned send_pct;
    bit          calm;
    rst_ni       = 1'b0;
    start        = 1'b0;
    kind_i       = 1'b0;
    mtype_i      = '0;
    msg_length_i = '0;
    payload_i    = '0;
    no_error_i   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty queue, zero lengths
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, '0, 16'd4, 32'h0, 1'b0), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, 32'd3, 16'd0, 32'hFFFF_FFFF, 1'b1), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'd3, 16'd0, 32'h1234_5678, 1'b0), 0);

    // fill to the top with extreme and ordinary entries
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                           1'b1), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'h8000_0000, 16'd1, 32'h0, 1'b0), 1);
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, -32'sd5, 16'd10, $urandom, 1'b0), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'd3, 16'd100, $urandom, 1'b0), 2);
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'd0, 16'd2, $urandom, 1'b0), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'd1, 16'd7, $urandom, 1'b0), 0);
    for (int i = 0; i < 10; i++) begin
      issue_command(make_cmd(tmqs_pkg::KIND_SEND, 100 + i, LEN_W'(i + 1), $urandom, 1'b0),
                    pick_gap(1'b0));
    end

    // full queue: zero length wins over full
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'd5, 16'd0, $urandom, 1'b0), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_SEND, 32'd5, 16'd5, $urandom, 1'b0), 0);

    // selector kinds, oversize refused then truncated
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, 32'd3, 16'd50, $urandom, 1'b0), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, 32'd3, 16'd50, $urandom, 1'b1), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, 32'h8000_0000, 16'hFFFF, $urandom, 1'b0), 3);
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, -32'sd4, 16'hFFFF, $urandom, 1'b0), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, 32'd7, 16'd20, $urandom, 1'b1), 0);
    issue_command(make_cmd(tmqs_pkg::KIND_RECV, 32'd0, 16'd1, $urandom, 1'b1), 0);
    wait_for_drain();

    // random bursts, each with its own send bias and idling mood
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      burst_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       send_pct = 15;
        1:       send_pct = 50;
        default: send_pct = 85;
      endcase
      calm = ($urandom_range(0, 2) == 0);
      repeat (burst_len) begin
        issue_command(random_command(send_pct), pick_gap(calm));
        issued++;
      end
      if ($urandom_range(0, 3) == 0) wait_for_drain();
    end

    // let the last results come back
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (queue_sb.error_count == 0 && queue_sb.expected_results.size() == 0) begin
      $display("typed_message_queue_select_core: match");
    end else begin
      $display("typed_message_queue_select_core: mismatch");
    end
    $finish;
  end

endmodule
